// ===== hw/rtl/itr_pkg.sv =====
// Shared constants and the digit-to-ASCII function of the integer-to-text converter.
package itr_pkg;

	localparam int DIGIT_W = 4;
	localparam int RADIX_W = 5;
	localparam int DIV_STEP_BITS = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 5'd10;

	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
		logic [7:0] glyph;
		if (digit < DIGIT_TEN) begin
			glyph = ASCII_ZERO + {4'd0, digit};
		end else begin
			glyph = ASCII_UPPER_A + {4'd0, digit - DIGIT_TEN};
		end
		return glyph;
	endfunction

endpackage

// ===== hw/rtl/integer_to_text_radix_core.sv =====
// Top level of the integer-to-text converter for bases 2 to 16.
// One request carries a two's-complement number and a radix (values below two act as two, values
// above sixteen as sixteen); the block answers with the ASCII characters of the number, most
// significant digit first, with last_char set on the final one. Radix ten is signed and puts a
// minus sign first; other radixes print the raw bit pattern as unsigned. Each digit needs one
// pass of the shared divider, which retires eight quotient bits per cycle, and each character is
// then read from the digit memory in ST_POP and loaded into the output register in ST_LOAD once
// that register is free. in_ready is high only while the block is idle.
module integer_to_text_radix_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_BITS-1:0]  number,
	input  logic [4:0]                    radix,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    character,
	output logic                          last_char
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SIGN,
		ST_POP,
		ST_LOAD
	} state_t;

	state_t                              state_q;
	logic                                neg_q;
	logic [VALUE_BITS-1:0]               mag_q;
	logic [itr_pkg::RADIX_W-1:0]         base_q;
	logic                                out_valid_q;
	logic [7:0]                          char_q;
	logic                                last_q;

	logic [itr_pkg::RADIX_W-1:0]         base_in;
	logic                                neg_in;
	logic                                in_fire;
	logic                                out_free;
	logic                                char_load;
	logic                                div_start;
	logic [VALUE_BITS-1:0]               div_quot;
	logic [itr_pkg::DIGIT_W-1:0]         div_rem;
	logic                                div_done;
	logic                                push;
	logic                                pop;
	logic [itr_pkg::DIGIT_W-1:0]         pop_digit;
	logic                                stack_empty;

	always_comb begin
		if (radix < itr_pkg::RADIX_MIN) begin
			base_in = itr_pkg::RADIX_MIN;
		end else if (radix > itr_pkg::RADIX_MAX) begin
			base_in = itr_pkg::RADIX_MAX;
		end else begin
			base_in = radix;
		end
	end

	assign neg_in = (base_in == itr_pkg::RADIX_DECIMAL) && number[VALUE_BITS-1];
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign char_load = out_free && ((state_q == ST_SIGN) || (state_q == ST_LOAD));
	assign div_start = (state_q == ST_DIV_START);
	assign push = (state_q == ST_DIV_WAIT) && div_done;
	assign pop = (state_q == ST_POP);

	itr_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (base_q),
		.quotient (div_quot),
		.remainder(div_rem),
		.done     (div_done)
	);

	itr_digit_stack #(
		.VALUE_BITS(VALUE_BITS)
	) u_digit_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_digit(div_rem),
		.pop       (pop),
		.pop_digit (pop_digit),
		.empty     (stack_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			char_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (char_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (div_quot != '0) begin
							state_q <= ST_DIV_START;
						end else if (neg_q) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						char_q <= itr_pkg::ASCII_MINUS;
						last_q <= 1'b0;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						char_q <= itr_pkg::digit_glyph(pop_digit);
						last_q <= stack_empty;
						state_q <= stack_empty ? ST_IDLE : ST_POP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q <= base_in;
			neg_q <= neg_in;
			mag_q <= neg_in ? (VALUE_BITS'(0) - number) : number;
		end else if (push) begin
			mag_q <= div_quot;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

// ===== hw/rtl/itr_divider.sv =====
// Iterative divider of the magnitude by the radix, several quotient bits per cycle.
module itr_divider #(
	parameter int VALUE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [VALUE_BITS-1:0]              dividend,
	input  logic [itr_pkg::RADIX_W-1:0]        divisor,
	output logic [VALUE_BITS-1:0]              quotient,
	output logic [itr_pkg::DIGIT_W-1:0]        remainder,
	output logic                               done
);

	localparam int STEP = itr_pkg::DIV_STEP_BITS;
	localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
	localparam int PAD_BITS = CHUNKS * STEP;
	localparam int CNT_W = $clog2(CHUNKS + 1);

	logic [PAD_BITS-1:0]               work_q;
	logic [itr_pkg::DIGIT_W-1:0]       rem_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              done_q;
	logic [STEP-1:0]                   qbits;
	logic [itr_pkg::DIGIT_W-1:0]       rem_next;

	always_comb begin
		logic [itr_pkg::RADIX_W-1:0] trial;
		logic [itr_pkg::DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP; i++) begin
			trial = {r, work_q[PAD_BITS-1-i]};
			if (trial >= divisor) begin
				trial = trial - divisor;
				qbits[STEP-1-i] = 1'b1;
			end
			r = trial[itr_pkg::DIGIT_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(CHUNKS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PAD_BITS'(dividend);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			work_q <= (work_q << STEP) | PAD_BITS'(qbits);
			rem_q <= rem_next;
		end
	end

	assign quotient = work_q[VALUE_BITS-1:0];
	assign remainder = rem_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/itr_digit_stack.sv =====
// Last-in first-out digit memory that turns the digit order around.
module itr_digit_stack #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [itr_pkg::DIGIT_W-1:0]   push_digit,
	input  logic                          pop,
	output logic [itr_pkg::DIGIT_W-1:0]   pop_digit,
	output logic                          empty
);

	localparam int AW = $clog2(VALUE_BITS);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [itr_pkg::DIGIT_W-1:0] mem [VALUE_BITS];
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            top_idx;
	logic [itr_pkg::DIGIT_W-1:0] rd_q;

	assign top_idx = count_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + 1'b1;
		end else if (pop) begin
			count_q <= top_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[count_q[AW-1:0]] <= push_digit;
		end
		if (pop) begin
			rd_q <= mem[top_idx[AW-1:0]];
		end
	end

	assign pop_digit = rd_q;
	assign empty = (count_q == '0);

endmodule

// ===== tb/sv/integer_to_text_radix_checker.sv =====
// Checker for the integer-to-text converter: predicts the characters of each request and compares them.
`timescale 1ns / 1ps

module integer_to_text_radix_checker #(
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [VALUE_BITS-1:0]           number,
	input  logic [itr_pkg::RADIX_W-1:0]     radix,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [7:0]                      character,
	input  logic                            last_char,
	output int                              mismatches,
	output int                              pending,
	output int                              requests_seen,
	output int                              chars_checked
);

	localparam string DIGIT_CHARS = "0123456789ABCDEF";

	logic [7:0] glyph_due[$];
	bit         last_due[$];

	int         fail_count = 0;
	int         request_count = 0;
	int         char_count = 0;
	logic [7:0] want_glyph;
	bit         want_last;

	function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
			input logic [itr_pkg::RADIX_W-1:0] rdx);
		logic [itr_pkg::RADIX_W-1:0] base;
		logic [VALUE_BITS-1:0]       magnitude;
		logic [7:0]                  glyphs[$];
		bit                          negative;
		int                          digit;
		if (rdx < itr_pkg::RADIX_MIN) begin
			base = itr_pkg::RADIX_MIN;
		end else if (rdx > itr_pkg::RADIX_MAX) begin
			base = itr_pkg::RADIX_MAX;
		end else begin
			base = rdx;
		end
		// Only decimal reads the value as signed; the most negative value wraps to its magnitude.
		negative = (base == itr_pkg::RADIX_DECIMAL) && value[VALUE_BITS-1];
		magnitude = negative ? -value : value;
		do begin
			digit = int'(magnitude % base);
			glyphs.push_front(DIGIT_CHARS[digit]);
			magnitude = magnitude / base;
		end while (magnitude != 0);
		if (negative) begin
			glyphs.push_front(itr_pkg::ASCII_MINUS);
		end
		foreach (glyphs[i]) begin
			glyph_due.push_back(glyphs[i]);
			last_due.push_back(i == glyphs.size() - 1);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_text(number, radix);
				request_count++;
			end
			if (out_valid && out_ready) begin
				if (glyph_due.size() == 0) begin
					$display("%0t: character %h (last %b) arrived with nothing expected",
						$time, character, last_char);
					fail_count++;
				end else begin
					want_glyph = glyph_due.pop_front();
					want_last = last_due.pop_front();
					if (character !== want_glyph) begin
						$display("%0t: character expected %h got %h", $time, want_glyph,
							character);
						fail_count++;
					end
					if (last_char !== want_last) begin
						$display("%0t: last_char expected %b got %b", $time, want_last,
							last_char);
						fail_count++;
					end
					char_count++;
				end
			end
		end
		mismatches <= fail_count;
		pending <= glyph_due.size();
		requests_seen <= request_count;
		chars_checked <= char_count;
	end

endmodule

// ===== tb/sv/integer_to_text_radix_core_tb.sv =====
// Testbench top for the integer-to-text converter: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module integer_to_text_radix_core_tb;

	localparam int VALUE_BITS = 32;
	localparam int RANDOM_REQUESTS = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} drain_mode_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [VALUE_BITS-1:0]      number = '0;
	logic [itr_pkg::RADIX_W-1:0]       radix = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [7:0]                        character;
	logic                              last_char;

	int          mismatches;
	int          pending;
	int          requests_seen;
	int          chars_checked;
	int          cycle_count = 0;
	drain_mode_t drain_mode = READY_ALWAYS;
	int          drain_left = 0;

	integer_to_text_radix_core #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.radix(radix),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last_char(last_char)
	);

	integer_to_text_radix_checker #(
		.VALUE_BITS(VALUE_BITS)
	) text_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.radix(radix),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last_char(last_char),
		.mismatches(mismatches),
		.pending(pending),
		.requests_seen(requests_seen),
		.chars_checked(chars_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver switches between readiness patterns in stretches of random length.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (drain_left == 0) begin
				drain_mode = drain_mode_t'($urandom_range(0, 3));
				drain_left = $urandom_range(16, 128);
			end
			drain_left--;
			case (drain_mode)
				READY_ALWAYS: begin
					out_ready <= 1'b1;
				end
				READY_COIN: begin
					out_ready <= ($urandom_range(0, 1) == 1);
				end
				READY_SPARSE: begin
					out_ready <= ($urandom_range(0, 7) == 0);
				end
				default: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	task automatic send_request(input logic [VALUE_BITS-1:0] value,
			input logic [itr_pkg::RADIX_W-1:0] rdx);
		in_valid <= 1'b1;
		number <= value;
		radix <= rdx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random_request();
		logic [VALUE_BITS-1:0]       value;
		logic [itr_pkg::RADIX_W-1:0] rdx;
		case ($urandom_range(0, 5))
			0: begin
				value = $urandom;
			end
			1: begin
				value = $urandom_range(0, 40);
			end
			2: begin
				value = -$urandom_range(1, 40);
			end
			3: begin
				value = $urandom_range(0, 65535);
			end
			4: begin
				case ($urandom_range(0, 5))
					0: value = '0;
					1: value = 32'd1;
					2: value = '1;
					3: value = 32'h7FFF_FFFF;
					4: value = 32'h8000_0000;
					default: value = 32'h8000_0001;
				endcase
			end
			default: begin
				value = $urandom >> $urandom_range(0, 31);
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			rdx = itr_pkg::RADIX_W'($urandom_range(0, 31));
		end else begin
			rdx = itr_pkg::RADIX_W'($urandom_range(2, 16));
		end
		send_request(value, rdx);
	endtask

	initial begin
		int sent;
		int burst;
		int gap;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(32'd0, 5'd10);
		send_request(32'd0, 5'd2);
		send_request(32'd0, 5'd16);
		send_request(32'h7FFF_FFFF, 5'd10);
		send_request(32'h8000_0000, 5'd10);
		send_request(32'hFFFF_FFFF, 5'd10);
		send_request(32'hFFFF_FFFF, 5'd2);
		send_request(32'h7FFF_FFFF, 5'd16);
		send_request(32'd12345, 5'd0);
		send_request(32'd12345, 5'd1);
		send_request(32'd12345, 5'd17);
		send_request(32'd12345, 5'd31);
		for (int r = 3; r < 16; r++) begin
			if (r != 10) begin
				send_request(32'hFEDC_BA98, itr_pkg::RADIX_W'(r));
			end
		end
		hold_until_drained();

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_random_request();
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				hold_until_drained();
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
				if (gap != 0) begin
					in_valid <= 1'b0;
					number <= VALUE_BITS'($urandom);
					radix <= itr_pkg::RADIX_W'($urandom);
					repeat (gap) @(posedge clk);
				end
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d requests into %0d checked characters.", requests_seen,
			chars_checked);
		$display("Bases 0 to 31, zero, both extremes and the most negative value were covered.");
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/itr_pkg.sv
hw/rtl/itr_divider.sv
hw/rtl/itr_digit_stack.sv
hw/rtl/integer_to_text_radix_core.sv
tb/sv/integer_to_text_radix_checker.sv
tb/sv/integer_to_text_radix_core_tb.sv
